### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, gated off while reset is high.
`define DDQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ddq assertion failed");

// Same-cycle implication.
`define DDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   `DDQ_ASSERT(lbl, clk, rst, (ante) |-> (cons))

`endif

### rtl/ddq_pkg.sv
package ddq_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      status_type status;
      logic       was_empty;
      logic       now_empty;
   } uop_ctl_type;

   typedef enum logic {
      BK_EXEC = 1'b0,
      BK_FILL = 1'b1
   } bk_state_type;

   localparam int CTL_WIDTH = $bits(uop_ctl_type);

endpackage

### rtl/ddq_front.sv
module ddq_front #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   localparam int AW        = $clog2(DEPTH),
   localparam int CW        = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ddq_pkg::cmd_type             req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         q_valid,
   input  logic                         q_ready,
   output ddq_pkg::uop_ctl_type         q_ctl,
   output logic signed [DATA_WIDTH-1:0] q_value,
   output logic [AW-1:0]                q_addr,
   output logic [CW-1:0]                q_count
);

   localparam int SW = CW + 1;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          full, empty;
   logic [AW-1:0] head_dec, head_inc, tail_slot, last_slot;
   logic [SW-1:0] tail_sum, last_sum;

   function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] s);
      if (s >= SW'(DEPTH)) begin
         return AW'(s - SW'(DEPTH));
      end
      return AW'(s);
   endfunction

   assign req_ready = q_ready;
   assign q_valid   = req_valid;
   assign q_value   = req_value;
   assign q_count   = count_in;
   assign q_addr    = (req_cmd == ddq_pkg::CMD_PUSH_FRONT) ? head_dec  :
                      (req_cmd == ddq_pkg::CMD_PUSH_BACK)  ? tail_slot :
                      (req_cmd == ddq_pkg::CMD_POP_FRONT)  ? head_inc  : last_slot;

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      empty     = (count_ff == '0);
      head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
      head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      tail_sum  = SW'(head_ff) + SW'(count_ff);
      last_sum  = tail_sum - SW'(2);
      tail_slot = wrap_slot(tail_sum);
      last_slot = wrap_slot(last_sum);
   end

   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      q_ctl.cmd        = req_cmd;
      q_ctl.status     = ddq_pkg::ST_DONE;
      case (req_cmd)
         ddq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               q_ctl.status = ddq_pkg::ST_FULL;
            end else begin
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         ddq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               q_ctl.status = ddq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ddq_pkg::CMD_POP_FRONT: begin
            if (empty) begin
               q_ctl.status = ddq_pkg::ST_EMPTY;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         ddq_pkg::CMD_POP_BACK: begin
            if (empty) begin
               q_ctl.status = ddq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            q_ctl.status = ddq_pkg::ST_DONE;
         end
      endcase
      q_ctl.was_empty = empty;
      q_ctl.now_empty = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (req_valid && q_ready) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/ddq_queue.sv
module ddq_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   localparam int SLOTS = 2;
   localparam int PW    = $clog2(SLOTS);
   localparam int FW    = $clog2(SLOTS + 1);

   logic [W-1:0]  slot_ff [SLOTS];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          push, pop;

   assign in_ready  = (fill_ff != FW'(SLOTS));
   assign out_valid = (fill_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + FW'(push) - FW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### rtl/ddq_back.sv
module ddq_back #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   localparam int AW        = $clog2(DEPTH),
   localparam int CW        = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  ddq_pkg::uop_ctl_type         q_ctl,
   input  logic signed [DATA_WIDTH-1:0] q_value,
   input  logic [AW-1:0]                q_addr,
   input  logic [CW-1:0]                q_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_popped,
   output logic signed [DATA_WIDTH-1:0] rsp_front,
   output logic signed [DATA_WIDTH-1:0] rsp_back,
   output logic [CW-1:0]                rsp_occupancy,
   output ddq_pkg::status_type          rsp_status
);

   logic signed [DATA_WIDTH-1:0] ring_mem [DEPTH];

   ddq_pkg::bk_state_type        state_ff, state_in;
   logic signed [DATA_WIDTH-1:0] front_word_ff, front_word_in;
   logic signed [DATA_WIDTH-1:0] back_word_ff, back_word_in;
   ddq_pkg::cmd_type             cur_cmd_ff;
   logic signed [DATA_WIDTH-1:0] cur_popped_ff;
   logic [CW-1:0]                cur_count_ff;
   logic signed [DATA_WIDTH-1:0] rdata_ff;
   logic                         out_valid_ff, out_valid_in;
   logic signed [DATA_WIDTH-1:0] popped_ff, front_ff, back_ff;
   logic [CW-1:0]                occ_ff;
   ddq_pkg::status_type          status_ff;

   logic                         out_free, is_pop, done, need_read;
   logic                         mem_we, mem_re, load_out;
   logic signed [DATA_WIDTH-1:0] word_sel, res_popped;
   logic [CW-1:0]                res_count;
   ddq_pkg::status_type          res_status;
   logic                         res_empty;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign is_pop    = (q_ctl.cmd == ddq_pkg::CMD_POP_FRONT) ||
                      (q_ctl.cmd == ddq_pkg::CMD_POP_BACK);
   assign done      = (q_ctl.status == ddq_pkg::ST_DONE);
   assign need_read = is_pop && done && !q_ctl.now_empty;
   assign word_sel  = (q_ctl.cmd == ddq_pkg::CMD_POP_FRONT) ? front_word_ff : back_word_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ddq_pkg::BK_EXEC: begin
            if (q_valid && need_read) begin
               state_in = ddq_pkg::BK_FILL;
            end
         end
         ddq_pkg::BK_FILL: begin
            if (out_free) begin
               state_in = ddq_pkg::BK_EXEC;
            end
         end
         default: begin
            state_in = ddq_pkg::BK_EXEC;
         end
      endcase
   end

   always_comb begin
      q_ready       = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      load_out      = 1'b0;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      res_popped    = '0;
      res_count     = q_count;
      res_status    = q_ctl.status;
      res_empty     = q_ctl.now_empty;
      case (state_ff)
         ddq_pkg::BK_EXEC: begin
            if (q_valid) begin
               if (need_read) begin
                  q_ready = 1'b1;
                  mem_re  = 1'b1;
               end else if (out_free) begin
                  q_ready  = 1'b1;
                  load_out = 1'b1;
                  mem_we   = done && !is_pop;
                  if (is_pop && done) begin
                     res_popped = word_sel;
                  end
                  if (done && (q_ctl.cmd == ddq_pkg::CMD_PUSH_FRONT)) begin
                     front_word_in = q_value;
                     if (q_ctl.was_empty) begin
                        back_word_in = q_value;
                     end
                  end
                  if (done && (q_ctl.cmd == ddq_pkg::CMD_PUSH_BACK)) begin
                     back_word_in = q_value;
                     if (q_ctl.was_empty) begin
                        front_word_in = q_value;
                     end
                  end
               end
            end
         end
         ddq_pkg::BK_FILL: begin
            res_popped = cur_popped_ff;
            res_count  = cur_count_ff;
            res_status = ddq_pkg::ST_DONE;
            res_empty  = 1'b0;
            if (out_free) begin
               load_out = 1'b1;
               if (cur_cmd_ff == ddq_pkg::CMD_POP_FRONT) begin
                  front_word_in = rdata_ff;
               end else begin
                  back_word_in = rdata_ff;
               end
            end
         end
         default: begin
            load_out = 1'b0;
         end
      endcase
      out_valid_in = load_out || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddq_pkg::BK_EXEC;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      if (mem_re) begin
         cur_cmd_ff    <= q_ctl.cmd;
         cur_popped_ff <= word_sel;
         cur_count_ff  <= q_count;
      end
      if (load_out) begin
         popped_ff <= res_popped;
         front_ff  <= res_empty ? '0 : front_word_in;
         back_ff   <= res_empty ? '0 : back_word_in;
         occ_ff    <= res_count;
         status_ff <= res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[q_addr] <= q_value;
      end
      if (mem_re) begin
         rdata_ff <= ring_mem[q_addr];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_popped    = popped_ff;
   assign rsp_front     = front_ff;
   assign rsp_back      = back_ff;
   assign rsp_occupancy = occ_ff;
   assign rsp_status    = status_ff;

endmodule

### rtl/double_ended_queue_top.sv
// Push, rejected word, or pop that empties: result is registered in the queue and output stage.
// Pop that leaves words also passes the registered read of the ring memory, taking no new word.
// Throughput: 1 word/cycle for pushes and rejects while rsp_tready does not stall the output.
// A 2-entry queue sits between the classifier and the ring execution unit.
// Reset clears pointers, count, queue and valid; ring contents stay undefined,
// no clearing pass.
module double_ended_queue_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   localparam int CW          = $clog2(DEPTH + 1),
   localparam int REQ_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_BITS    = 3 * DATA_WIDTH + CW,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // push_value
   input  logic [1:0]             req_tuser,   // cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // popped_value, front_value, back_value, occupancy
   output logic [1:0]             rsp_tuser    // status
);

   localparam int AW = $clog2(DEPTH);
   localparam int QW = ddq_pkg::CTL_WIDTH + DATA_WIDTH + AW + CW;

   ddq_pkg::uop_ctl_type         fr_ctl, bk_ctl;
   logic signed [DATA_WIDTH-1:0] fr_value, bk_value;
   logic [AW-1:0]                fr_addr, bk_addr;
   logic [CW-1:0]                fr_count, bk_count;
   logic                         fr_valid, fr_ready, bk_valid, bk_ready;
   logic [QW-1:0]                q_out;

   logic signed [DATA_WIDTH-1:0] popped, front, back;
   logic [CW-1:0]                occupancy;
   ddq_pkg::status_type          status;

   ddq_front #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (ddq_pkg::cmd_type'(req_tuser)),
      .req_value (req_tdata[DATA_WIDTH-1:0]),
      .q_valid   (fr_valid),
      .q_ready   (fr_ready),
      .q_ctl     (fr_ctl),
      .q_value   (fr_value),
      .q_addr    (fr_addr),
      .q_count   (fr_count)
   );

   ddq_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   ({fr_ctl, fr_value, fr_addr, fr_count}),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (q_out)
   );

   assign {bk_ctl, bk_value, bk_addr, bk_count} = q_out;

   ddq_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (bk_valid),
      .q_ready       (bk_ready),
      .q_ctl         (bk_ctl),
      .q_value       (bk_value),
      .q_addr        (bk_addr),
      .q_count       (bk_count),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_popped    (popped),
      .rsp_front     (front),
      .rsp_back      (back),
      .rsp_occupancy (occupancy),
      .rsp_status    (status)
   );

   assign rsp_tdata = RSP_TDATA_W'({occupancy, back, front, popped});
   assign rsp_tuser = status;

endmodule

### rtl/ddq_checker.sv
`include "assert_macros.svh"

module ddq_checker #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   localparam int CW          = $clog2(DEPTH + 1),
   localparam int RSP_BITS    = 3 * DATA_WIDTH + CW,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   logic [DATA_WIDTH-1:0] popped, front, back;
   logic [CW-1:0]         occ;

   assign popped = rsp_tdata[DATA_WIDTH-1:0];
   assign front  = rsp_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
   assign back   = rsp_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
   assign occ    = rsp_tdata[RSP_BITS-1:3*DATA_WIDTH];

   `DDQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `DDQ_ASSERT_IMPL(a_occ_range, clock, reset, rsp_tvalid, occ <= DEPTH)
   `DDQ_ASSERT_IMPL(a_full_count, clock, reset, rsp_tvalid && rsp_tuser == ddq_pkg::ST_FULL, occ == DEPTH)
   `DDQ_ASSERT_IMPL(a_empty_reject, clock, reset, rsp_tvalid && rsp_tuser == ddq_pkg::ST_EMPTY, occ == 0 && popped == 0)
   `DDQ_ASSERT_IMPL(a_empty_peek, clock, reset, rsp_tvalid && occ == 0, front == 0 && back == 0)

endmodule

bind double_ended_queue_top ddq_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_ddq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/double_ended_queue_top_test.sv
`timescale 1ns / 1ps

module double_ended_queue_top_test;

   localparam int RING_DEPTH   = 16;
   localparam int WORD_W       = 32;
   localparam int RSP_W        = 104;
   localparam int RANDOM_ITEMS = 1900;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      ddq_pkg::cmd_type cmd;
      logic [31:0]      value;
   } deque_op_type;

   typedef struct {
      logic [31:0]         popped;
      logic [31:0]         front;
      logic [31:0]         back;
      logic [4:0]          occupancy;
      ddq_pkg::status_type status;
   } deque_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [WORD_W-1:0]  req_tdata = '0;   // push_value
   logic [1:0]         req_tuser = '0;   // cmd
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;        // popped_value, front_value, back_value, occupancy
   logic [1:0]         rsp_tuser;        // status

   deque_op_type     op_stream[$];
   deque_reply_type  queued_replies[$];

   logic [31:0] shadow_ring [RING_DEPTH];
   logic [3:0]  shadow_head = '0;
   logic [4:0]  shadow_count = '0;

   int          error_count = 0;
   int          push_done = 0;
   int          pop_done = 0;
   int          full_rejects = 0;
   int          empty_rejects = 0;
   int          replies_seen = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;

   double_ended_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic deque_reply_type deque_apply(deque_op_type op);
      deque_reply_type r;
      logic [3:0] tail;
      r.popped = '0;
      r.front = '0;
      r.back = '0;
      r.status = ddq_pkg::ST_DONE;
      case (op.cmd)
         ddq_pkg::CMD_PUSH_FRONT, ddq_pkg::CMD_PUSH_BACK: begin
            if (shadow_count == RING_DEPTH) begin
               r.status = ddq_pkg::ST_FULL;
               full_rejects++;
            end else if (op.cmd == ddq_pkg::CMD_PUSH_FRONT) begin
               shadow_head = shadow_head - 4'd1;
               shadow_ring[shadow_head] = op.value;
               shadow_count++;
               push_done++;
            end else begin
               shadow_ring[shadow_head + shadow_count[3:0]] = op.value;
               shadow_count++;
               push_done++;
            end
         end
         default: begin
            if (shadow_count == 0) begin
               r.status = ddq_pkg::ST_EMPTY;
               empty_rejects++;
            end else if (op.cmd == ddq_pkg::CMD_POP_FRONT) begin
               r.popped = shadow_ring[shadow_head];
               shadow_head = shadow_head + 4'd1;
               shadow_count--;
               pop_done++;
            end else begin
               tail = shadow_head + shadow_count[3:0] - 4'd1;
               r.popped = shadow_ring[tail];
               shadow_count--;
               pop_done++;
            end
         end
      endcase
      if (shadow_count != 0) begin
         tail = shadow_head + shadow_count[3:0] - 4'd1;
         r.front = shadow_ring[shadow_head];
         r.back = shadow_ring[tail];
      end
      r.occupancy = shadow_count;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         4: return 32'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   task automatic add_op(ddq_pkg::cmd_type cmd, logic [31:0] value);
      deque_op_type op;
      op.cmd = cmd;
      op.value = value;
      op_stream.push_back(op);
   endtask

   always @(posedge clock) begin
      logic send;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            queued_replies.push_back(deque_apply(op_stream[0]));
            void'(op_stream.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            send = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (op_stream.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 11) - 1;
            end else begin
               send = (op_stream.size() > 0);
            end
            if (send) begin
               req_tvalid <= 1'b1;
               req_tuser <= op_stream[0].cmd;
               req_tdata <= op_stream[0].value;
            end else begin
               req_tvalid <= 1'b0;
               req_tuser <= ddq_pkg::cmd_type'($urandom_range(0, 3));
               req_tdata <= $urandom;
            end
         end
      end
   end

   always @(posedge clock) begin
      deque_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            if (queued_replies.size() == 0) begin
               $error("unexpected result word: tdata %h tuser %0d", rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = queued_replies.pop_front();
               if (rsp_tdata[31:0] !== want.popped) begin
                  $error("popped_value: expected %0d, actual %0d",
                         $signed(want.popped), $signed(rsp_tdata[31:0]));
                  error_count++;
               end
               if (rsp_tdata[63:32] !== want.front) begin
                  $error("front_value: expected %0d, actual %0d",
                         $signed(want.front), $signed(rsp_tdata[63:32]));
                  error_count++;
               end
               if (rsp_tdata[95:64] !== want.back) begin
                  $error("back_value: expected %0d, actual %0d",
                         $signed(want.back), $signed(rsp_tdata[95:64]));
                  error_count++;
               end
               if (rsp_tdata[100:96] !== want.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d",
                         want.occupancy, rsp_tdata[100:96]);
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (op_stream.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int added;
      int seg_len;
      int push_pct;
      ddq_pkg::cmd_type cmd;

      foreach (shadow_ring[i]) shadow_ring[i] = '0;

      // empty-deque pops, extreme words at both ends, drain back to empty, then an empty pop and a push/pop pair
      add_op(ddq_pkg::CMD_POP_FRONT, 32'h1234_5678);
      add_op(ddq_pkg::CMD_POP_BACK, 32'hffff_ffff);
      add_op(ddq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
      add_op(ddq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
      add_op(ddq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
      add_op(ddq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
      add_op(ddq_pkg::CMD_POP_BACK, 32'h0);
      add_op(ddq_pkg::CMD_POP_FRONT, 32'h0);
      add_op(ddq_pkg::CMD_POP_FRONT, 32'h0);
      add_op(ddq_pkg::CMD_POP_BACK, 32'h0);
      add_op(ddq_pkg::CMD_POP_BACK, 32'h0);
      add_op(ddq_pkg::CMD_PUSH_BACK, 32'h5555_aaaa);
      add_op(ddq_pkg::CMD_POP_FRONT, 32'haaaa_5555);

      added = 0;
      while (added < RANDOM_ITEMS) begin
         seg_len = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         repeat (seg_len) begin
            if ($urandom_range(0, 99) < push_pct)
               cmd = $urandom_range(0, 1) ? ddq_pkg::CMD_PUSH_BACK : ddq_pkg::CMD_PUSH_FRONT;
            else
               cmd = $urandom_range(0, 1) ? ddq_pkg::CMD_POP_BACK : ddq_pkg::CMD_POP_FRONT;
            add_op(cmd, pick_word());
            added++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (op_stream.size() != 0 || req_tvalid) @(posedge clock);
      while (queued_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results: %0d pushes, %0d pops stored or removed",
               replies_seen, push_done, pop_done);
      $display("rejected: %0d pushes on a full deque, %0d pops on an empty one",
               full_rejects, empty_rejects);
      if (error_count == 0 && queued_replies.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### double_ended_queue_top.f
+incdir+rtl
rtl/ddq_pkg.sv
rtl/ddq_front.sv
rtl/ddq_queue.sv
rtl/ddq_back.sv
rtl/double_ended_queue_top.sv
rtl/ddq_checker.sv
tb/double_ended_queue_top_test.sv
